/* rtl/core/header_value_extractor_top_assert.svh */
// ---------------------------------------------------------------------------
// header value extractor assertion macros
// property wrappers on clock and reset, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef HEADER_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define HEADER_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HVE_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hve assertion failed");
// next-cycle implication
`define HVE_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hve assertion failed");
`else
`define HVE_ASSERT_IMP(name, ante, cons)
`define HVE_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* rtl/core/hve_pkg.sv */
// ---------------------------------------------------------------------------
// hve_pkg
// shared widths, character codes, mode codes and state types
// ---------------------------------------------------------------------------
`default_nettype none
package hve_pkg;
   localparam int DATA_W  = 8;
   localparam int MODE_W  = 2;
   localparam int SLOT_W  = 3;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 4;
   localparam int LEN_W   = 6;
   localparam int PROG_W  = 5;

   localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;
   localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;

   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BYTE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      PH_SCAN  = 2'd0,
      PH_COLON = 2'd1,
      PH_SPACE = 2'd2,
      PH_VALUE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_SCAN = 2'd2
   } fsm_type;
endpackage
`default_nettype wire

/* rtl/core/hve_req_if.sv */
// ---------------------------------------------------------------------------
// hve_req_if
// request channel: key loads, message bytes and end of buffer
// ---------------------------------------------------------------------------
`default_nettype none
interface hve_req_if;
   import hve_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [DATA_W-1:0]     data_byte;
   logic [DATA_W-1:0]     key_char;
   logic [SLOT_W-1:0]     key_slot;
   logic [INDEX_W-1:0]    char_index;
   logic                  char_last;

   modport source (output valid, mode, data_byte, key_char, key_slot, char_index,
                   char_last, input ready);
   modport sink   (input valid, mode, data_byte, key_char, key_slot, char_index,
                   char_last, output ready);
endinterface
`default_nettype wire

/* rtl/core/hve_rsp_if.sv */
// ---------------------------------------------------------------------------
// hve_rsp_if
// response channel: value bytes and end markers
// ---------------------------------------------------------------------------
`default_nettype none
interface hve_rsp_if;
   import hve_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [SLOT_W-1:0]     slot_found;
   logic [DATA_W-1:0]     value_byte;
   logic                  byte_valid;
   logic                  value_end;
   logic                  no_separator;
   logic [COUNT_W-1:0]    found_count;

   modport source (output valid, slot_found, value_byte, byte_valid, value_end,
                   no_separator, found_count, input ready);
   modport sink   (input valid, slot_found, value_byte, byte_valid, value_end,
                   no_separator, found_count, output ready);
endinterface
`default_nettype wire

/* rtl/core/hve_key_ram.sv */
// ---------------------------------------------------------------------------
// hve_key_ram
// key text store, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none
module hve_key_ram #(
   parameter int AW = 8
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [hve_pkg::DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr_a,
   input  wire logic [AW-1:0]             rd_addr_b,
   output logic      [hve_pkg::DATA_W-1:0] rd_data_a,
   output logic      [hve_pkg::DATA_W-1:0] rd_data_b
);
   import hve_pkg::*;

   logic [DATA_W-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

/* rtl/core/header_value_extractor_top.sv */
// ---------------------------------------------------------------------------
// header value extractor
// finds loaded key names in a byte stream and streams out their values
// ---------------------------------------------------------------------------
// usage:
//   req_chan carries one word per item: a key character load (mode 0), a
//   message byte (mode 1) or an end of buffer marker (mode 2).
//   rsp_chan returns at most one word per item: a value byte, an end marker
//   or a flagged empty word when a key lacks its colon and space.
//   csr_* writes keys_in_use; write it only while the block is idle.
// sequencing:
//   every item is accepted in the idle state and then handled in the
//   execute state, which writes any response word to the output register.
//   a scanned message byte then runs the scan over n = min(keys_in_use,
//   MAX_KEYS) slots: one key text read pair per slot through the two read
//   ports of the key memory, pipelined one slot per cycle through the issue
//   and eval stages, then the eval stage drains; a key found stops the scan.
//   a new item is accepted only once the last has left execute and scan.
// reset:
//   clears phase, counts, key lengths, progress and reported marks; key
//   text is not cleared and has no meaning until loaded, no clearing pass.
// stall:
//   the output register holds its word while rsp_chan.ready is low; the
//   next item is still accepted and runs until it needs the register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "header_value_extractor_top_assert.svh"
module header_value_extractor_top #(
   parameter int MAX_KEYS    = 8,
   parameter int MAX_KEY_LEN = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   hve_req_if.sink                          req_chan,
   hve_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [hve_pkg::COUNT_W-1:0] csr_data
);
   import hve_pkg::*;

   // slot index, key character index, slot counter and compare widths
   localparam int SW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int LW = $clog2(MAX_KEY_LEN);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int AW = SW + LW;

   // control state
   fsm_type              state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [SW-1:0]        active_ff, active_in;
   logic                 after_cr_ff, after_cr_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [COUNT_W-1:0]   kiu_ff;

   // accepted word
   logic [MODE_W-1:0]    mode_ff;
   logic [DATA_W-1:0]    byte_ff;
   logic [DATA_W-1:0]    kchar_ff;
   logic [SLOT_W-1:0]    kslot_ff;
   logic [INDEX_W-1:0]   kidx_ff;
   logic                 klast_ff;

   // per slot state
   logic [LEN_W-1:0]     len_ff  [MAX_KEYS];
   logic [PROG_W-1:0]    prog_ff [MAX_KEYS];
   logic                 rep_ff  [MAX_KEYS];

   // scan pipeline: issue stage reads key text, eval stage compares
   logic [CW-1:0]        iss_ff, iss_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [SW-1:0]        eval_slot_ff, eval_slot_in;
   logic [PROG_W-1:0]    eval_prog_ff, eval_prog_in;

   // output register
   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [DATA_W-1:0]    rsp_byte_ff;
   logic                 rsp_bvld_ff;
   logic                 rsp_end_ff;
   logic                 rsp_nosep_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 req_fire;
   logic                 out_free;

   // execute stage proposals
   logic                 ex_res_vld;
   logic [DATA_W-1:0]    ex_res_byte;
   logic                 ex_res_bvld;
   logic                 ex_res_end;
   logic                 ex_res_nosep;
   phase_type            ex_phase;
   logic                 ex_after_cr;
   logic                 ex_go_scan;
   logic                 ex_clear;
   logic                 ex_load;
   logic                 exec_fire;

   // load addressing
   logic [SW+SLOT_W-1:0] ld_slot_ext;
   logic [SW-1:0]        ld_slot;
   logic [LW+INDEX_W-1:0] ld_idx_ext;
   logic [LW-1:0]        ld_idx;
   logic                 ld_ok;

   // scan signals
   logic [NW-1:0]        n_eff;
   logic [SW-1:0]        iss_slot;
   logic [PROG_W-1:0]    iss_p0;
   logic [LW+PROG_W-1:0] iss_p_ext;
   logic                 iss_more;
   logic                 issue_en;
   logic [LEN_W-1:0]     ev_len;
   logic                 ev_skip;
   logic [LEN_W-1:0]     ev_p1;
   logic                 scan_hit;
   logic                 scan_done;
   logic                 ev_wr;
   logic [DATA_W-1:0]    txt_p;
   logic [DATA_W-1:0]    txt_0;
   logic [AW-1:0]        rd_addr_a;
   logic [AW-1:0]        rd_addr_b;
   logic [SW+SLOT_W-1:0] act_ext;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign csr_ready = 1'b1;

   // keys_in_use register
   always_ff @(posedge clock) begin
      if (reset) begin
         kiu_ff <= '0;
      end else if (csr_valid) begin
         kiu_ff <= csr_data;
      end
   end

   // hold the accepted word for the execute and scan steps
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff  <= req_chan.mode;
         byte_ff  <= req_chan.data_byte;
         kchar_ff <= req_chan.key_char;
         kslot_ff <= req_chan.key_slot;
         kidx_ff  <= req_chan.char_index;
         klast_ff <= req_chan.char_last;
      end
   end

   // load address, out of range loads are dropped
   assign ld_slot_ext = {{SW{1'b0}}, kslot_ff};
   assign ld_slot     = ld_slot_ext[SW-1:0];
   assign ld_idx_ext  = {{LW{1'b0}}, kidx_ff};
   assign ld_idx      = ld_idx_ext[LW-1:0];
   assign ld_ok       = (32'(kslot_ff) < MAX_KEYS) && (32'(kidx_ff) < MAX_KEY_LEN);

   // execute step: everything except the key scan
   always_comb begin
      ex_res_vld   = 1'b0;
      ex_res_byte  = '0;
      ex_res_bvld  = 1'b0;
      ex_res_end   = 1'b0;
      ex_res_nosep = 1'b0;
      ex_phase     = phase_ff;
      ex_after_cr  = after_cr_ff;
      ex_go_scan   = 1'b0;
      ex_clear     = 1'b0;
      ex_load      = 1'b0;
      unique case (mode_ff)
         MODE_LOAD: begin
            ex_load = ld_ok;
         end
         MODE_BYTE: begin
            unique case (phase_ff)
               PH_SCAN: begin
                  ex_go_scan = 1'b1;
               end
               PH_COLON: begin
                  if (byte_ff == CH_COLON) begin
                     ex_phase = PH_SPACE;
                  end else begin
                     // missing separator, flag and rescan this byte
                     ex_res_vld   = 1'b1;
                     ex_res_end   = 1'b1;
                     ex_res_nosep = 1'b1;
                     ex_phase     = PH_SCAN;
                     ex_go_scan   = 1'b1;
                  end
               end
               PH_SPACE: begin
                  if (byte_ff == CH_SPACE) begin
                     ex_phase    = PH_VALUE;
                     ex_after_cr = 1'b0;
                  end else begin
                     ex_res_vld   = 1'b1;
                     ex_res_end   = 1'b1;
                     ex_res_nosep = 1'b1;
                     ex_phase     = PH_SCAN;
                     ex_go_scan   = 1'b1;
                  end
               end
               PH_VALUE: begin
                  if (after_cr_ff) begin
                     // lf closes the value, anything else after cr is dropped
                     ex_after_cr = 1'b0;
                     if (byte_ff == CH_LF) begin
                        ex_res_vld = 1'b1;
                        ex_res_end = 1'b1;
                        ex_phase   = PH_SCAN;
                     end
                  end else if (byte_ff == CH_CR) begin
                     ex_after_cr = 1'b1;
                  end else begin
                     ex_res_vld  = 1'b1;
                     ex_res_byte = byte_ff;
                     ex_res_bvld = 1'b1;
                  end
               end
               default: begin
                  ex_phase = PH_SCAN;
               end
            endcase
         end
         MODE_END: begin
            // close an open value or a pending separator, then clear the buffer
            if (phase_ff == PH_VALUE) begin
               ex_res_vld = 1'b1;
               ex_res_end = 1'b1;
            end else if (phase_ff == PH_COLON || phase_ff == PH_SPACE) begin
               ex_res_vld   = 1'b1;
               ex_res_end   = 1'b1;
               ex_res_nosep = 1'b1;
            end
            ex_clear    = 1'b1;
            ex_after_cr = 1'b0;
            ex_phase    = PH_SCAN;
         end
         default: begin
         end
      endcase
   end

   // execute waits only when it has a word and the output register is busy
   assign exec_fire = (state_ff == ST_EXEC) && (!ex_res_vld || out_free);

   // number of slots that take part, saturated to MAX_KEYS
   always_comb begin
      n_eff = NW'(kiu_ff);
      if (n_eff > NW'(MAX_KEYS)) begin
         n_eff = NW'(MAX_KEYS);
      end
   end

   // issue stage: start point for this slot, restart when at or beyond the length
   assign iss_slot  = iss_ff[SW-1:0];
   assign iss_more  = NW'(iss_ff) < n_eff;
   assign iss_p0    = ({1'b0, prog_ff[iss_slot]} >= len_ff[iss_slot]) ? '0 :
                      prog_ff[iss_slot];
   assign iss_p_ext = {{LW{1'b0}}, iss_p0};
   assign rd_addr_a = {iss_slot, iss_p_ext[LW-1:0]};
   assign rd_addr_b = {iss_slot, {LW{1'b0}}};

   // eval stage: naive match with retest against the first character
   assign ev_len  = len_ff[eval_slot_ff];
   assign ev_skip = rep_ff[eval_slot_ff] || (ev_len == '0);
   always_comb begin
      if (byte_ff == txt_p) begin
         ev_p1 = {1'b0, eval_prog_ff} + LEN_W'(1);
      end else if (byte_ff == txt_0) begin
         ev_p1 = LEN_W'(1);
      end else begin
         ev_p1 = '0;
      end
   end
   assign ev_wr     = (state_ff == ST_SCAN) && eval_vld_ff && !ev_skip;
   assign scan_hit  = ev_wr && (ev_p1 >= ev_len);
   assign scan_done = (state_ff == ST_SCAN) && !eval_vld_ff && !iss_more;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ex_go_scan ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs: handshake and scan pipeline control
   always_comb begin
      req_chan.ready = 1'b0;
      issue_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_EXEC: begin
         end
         ST_SCAN: begin
            issue_en = !scan_hit && iss_more;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      iss_in       = iss_ff;
      eval_vld_in  = 1'b0;
      eval_slot_in = eval_slot_ff;
      eval_prog_in = eval_prog_ff;
      if (state_ff != ST_SCAN) begin
         iss_in = '0;
      end else if (issue_en) begin
         iss_in       = iss_ff + CW'(1);
         eval_vld_in  = 1'b1;
         eval_slot_in = iss_slot;
         eval_prog_in = iss_p0;
      end
   end

   // buffer level state
   always_comb begin
      phase_in    = phase_ff;
      after_cr_in = after_cr_ff;
      active_in   = active_ff;
      total_in    = total_ff;
      if (exec_fire) begin
         phase_in    = ex_phase;
         after_cr_in = ex_after_cr;
         if (ex_clear) begin
            total_in = '0;
         end
      end else if (scan_hit) begin
         // key found: count it now and wait for the separator
         phase_in  = PH_COLON;
         active_in = eval_slot_ff;
         if (total_ff != COUNT_MAX) begin
            total_in = total_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_SCAN;
         after_cr_ff <= 1'b0;
         active_ff   <= '0;
         total_ff    <= '0;
         iss_ff      <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         after_cr_ff <= after_cr_in;
         active_ff   <= active_in;
         total_ff    <= total_in;
         iss_ff      <= iss_in;
         eval_vld_ff <= eval_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_slot_ff <= eval_slot_in;
      eval_prog_ff <= eval_prog_in;
   end

   // per slot length, progress and reported marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KEYS; i++) begin
            len_ff[i]  <= '0;
            prog_ff[i] <= '0;
            rep_ff[i]  <= 1'b0;
         end
      end else begin
         if (exec_fire && ex_clear) begin
            for (int i = 0; i < MAX_KEYS; i++) begin
               prog_ff[i] <= '0;
               rep_ff[i]  <= 1'b0;
            end
         end
         if (exec_fire && ex_load) begin
            prog_ff[ld_slot] <= '0;
            if (klast_ff) begin
               len_ff[ld_slot] <= {1'b0, kidx_ff} + LEN_W'(1);
            end
         end
         if (ev_wr) begin
            prog_ff[eval_slot_ff] <= scan_hit ? '0 : ev_p1[PROG_W-1:0];
            if (scan_hit) begin
               rep_ff[eval_slot_ff] <= 1'b1;
            end
         end
      end
   end

   hve_key_ram #(
      .AW (AW)
   ) u_key_ram (
      .clock     (clock),
      .wr_en     (exec_fire && ex_load),
      .wr_addr   ({ld_slot, ld_idx}),
      .wr_data   (kchar_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (txt_p),
      .rd_data_b (txt_0)
   );

   // output register, word carries the slot and count at emit time
   assign act_ext = {{SLOT_W{1'b0}}, active_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire && ex_res_vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && ex_res_vld) begin
         rsp_slot_ff  <= act_ext[SLOT_W-1:0];
         rsp_byte_ff  <= ex_res_byte;
         rsp_bvld_ff  <= ex_res_bvld;
         rsp_end_ff   <= ex_res_end;
         rsp_nosep_ff <= ex_res_nosep;
         rsp_count_ff <= total_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.slot_found   = rsp_slot_ff;
   assign rsp_chan.value_byte   = rsp_byte_ff;
   assign rsp_chan.byte_valid   = rsp_bvld_ff;
   assign rsp_chan.value_end    = rsp_end_ff;
   assign rsp_chan.no_separator = rsp_nosep_ff;
   assign rsp_chan.found_count  = rsp_count_ff;

   // checks
   `HVE_ASSERT_IMP(a_eval_only_in_scan, eval_vld_ff, state_ff == ST_SCAN)
   `HVE_ASSERT_IMP(a_scan_phase, state_ff == ST_SCAN, phase_ff == PH_SCAN)
   `HVE_ASSERT_NXT(a_hit_to_colon, scan_hit, phase_ff == PH_COLON && state_ff == ST_IDLE)
   `HVE_ASSERT_NXT(a_emit_loads_out, exec_fire && ex_res_vld, rsp_valid_ff)
endmodule
`default_nettype wire
